### hw/rtl/lutf8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lutf8_pkg
// Shared types and constants of the lenient UTF-8 decoder.
// ----------------------------------------------------------------------------
package lutf8_pkg;

    // byte classification limits
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;

    // payload masks for lead and continuation bytes
    localparam logic [7:0] LEAD2_MASK  = 8'h1F;
    localparam logic [7:0] LEAD3_MASK  = 8'h0F;
    localparam logic [7:0] LEAD4_MASK  = 8'h07;
    localparam logic [7:0] TAIL_MASK   = 8'h3F;

    // sequence length codes
    localparam logic [2:0] LEN_IDLE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    // held byte counts
    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_ONE   = 2'd1;
    localparam logic [1:0] HELD_TWO   = 2'd2;
    localparam logic [1:0] HELD_THREE = 2'd3;

    // default queue depths
    localparam int CMD_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_zero;
        logic       is_ascii;
        logic       is_cont;
        logic [2:0] lead_len;
    } t_cmd;

    // one result transaction
    typedef struct packed {
        logic [20:0] code_point;
        logic        end_of_string;
        logic        last;
    } t_res;

endpackage

### hw/rtl/lutf8_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lutf8_fifo
// Small register FIFO with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module lutf8_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == FULL_CNT);
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
        end
        if (w_do_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### hw/rtl/lutf8_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lutf8_front
// Accepts raw bytes, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module lutf8_front #(
    parameter int CMD_DEPTH = lutf8_pkg::CMD_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [7:0]        i_in_byte,
    output logic              o_full,
    input  logic              i_cmd_pop,
    output lutf8_pkg::t_cmd   o_cmd,
    output logic              o_cmd_empty
);
    import lutf8_pkg::*;

    t_cmd w_cmd;

    // classify the byte: zero, ASCII, continuation, lead length
    always_comb begin
        w_cmd.data     = i_in_byte;
        w_cmd.is_zero  = (i_in_byte == 8'h00);
        w_cmd.is_ascii = (i_in_byte < ASCII_LIMIT);
        w_cmd.is_cont  = ((i_in_byte & CONT_MASK) == CONT_TAG);
        if (i_in_byte < LEAD3_MIN) begin
            w_cmd.lead_len = LEN_TWO;
        end else if (i_in_byte < LEAD4_MIN) begin
            w_cmd.lead_len = LEN_THREE;
        end else begin
            w_cmd.lead_len = LEN_FOUR;
        end
    end

    // command queue toward the back end
    lutf8_fifo #(
        .DEPTH (CMD_DEPTH),
        .WIDTH ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );

endmodule

### hw/rtl/lutf8_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lutf8_back
// Sequence state machine: holds lead and continuation bytes, builds code
// points and queues results.
// ----------------------------------------------------------------------------
module lutf8_back #(
    parameter int RES_DEPTH = lutf8_pkg::RES_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lutf8_pkg::t_cmd   i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output lutf8_pkg::t_res   o_res,
    output logic              o_res_empty,
    input  logic              i_res_pop
);
    import lutf8_pkg::*;

    logic [7:0]  r_held0, n_held0;
    logic [7:0]  r_held1, n_held1;
    logic [7:0]  r_held2, n_held2;
    logic [1:0]  r_count, n_count;
    logic [2:0]  r_len, n_len;

    logic        w_res_full;
    logic        w_fire;
    logic        w_push;
    logic        w_replay;
    logic        w_closes;
    t_res        w_res;
    logic [20:0] w_full_cp;
    logic [20:0] w_pair_cp;
    logic [7:0]  w_tail;

    assign w_fire = !i_cmd_empty && !w_res_full;
    assign w_tail = i_cmd.data & TAIL_MASK;

    // code point of the open sequence closed by this continuation
    always_comb begin
        case (r_len)
            LEN_TWO: begin
                w_full_cp = {10'd0, 5'(r_held0 & LEAD2_MASK), 6'(w_tail)};
            end
            LEN_THREE: begin
                w_full_cp = {5'd0, 4'(r_held0 & LEAD3_MASK),
                             6'(r_held1 & TAIL_MASK), 6'(w_tail)};
            end
            default: begin
                w_full_cp = {3'(r_held0 & LEAD4_MASK), 6'(r_held1 & TAIL_MASK),
                             6'(r_held2 & TAIL_MASK), 6'(w_tail)};
            end
        endcase
    end

    // replay of two held continuations: first acts as a two-byte lead
    assign w_pair_cp = {10'd0, 5'(r_held1 & LEAD2_MASK), 6'(r_held2 & TAIL_MASK)};
    assign w_closes  = ({1'b0, r_count} + 3'd1) >= r_len;

    // next state and result
    always_comb begin
        n_held0  = r_held0;
        n_held1  = r_held1;
        n_held2  = r_held2;
        n_count  = r_count;
        n_len    = r_len;
        w_push   = 1'b0;
        w_replay = 1'b0;
        w_res    = '{code_point: '0, end_of_string: 1'b0, last: 1'b1};
        if (w_fire) begin
            if (r_count == HELD_NONE) begin
                if (i_cmd.is_zero) begin
                    w_push              = 1'b1;
                    w_res.end_of_string = 1'b1;
                end else if (i_cmd.is_ascii) begin
                    w_push           = 1'b1;
                    w_res.code_point = {13'd0, i_cmd.data};
                end else begin
                    n_held0 = i_cmd.data;
                    n_count = HELD_ONE;
                    n_len   = i_cmd.lead_len;
                end
            end else if (i_cmd.is_cont) begin
                if (w_closes) begin
                    w_push           = 1'b1;
                    w_res.code_point = w_full_cp;
                    n_count          = HELD_NONE;
                    n_len            = LEN_IDLE;
                end else if (r_count == HELD_ONE) begin
                    n_held1 = i_cmd.data;
                    n_count = HELD_TWO;
                end else begin
                    n_held2 = i_cmd.data;
                    n_count = HELD_THREE;
                end
            end else begin
                // bad continuation: drop the lead, revisit this byte from idle
                w_replay = 1'b1;
                n_count  = HELD_NONE;
                n_len    = LEN_IDLE;
                if (r_count == HELD_THREE) begin
                    w_push           = 1'b1;
                    w_res.code_point = w_pair_cp;
                    w_res.last       = !(i_cmd.is_zero || i_cmd.is_ascii);
                end
            end
        end
    end

    assign o_cmd_pop = w_fire && !w_replay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= HELD_NONE;
            r_len   <= LEN_IDLE;
        end else begin
            r_count <= n_count;
            r_len   <= n_len;
        end
    end

    // held bytes, no reset
    always_ff @(posedge i_clk) begin
        r_held0 <= n_held0;
        r_held1 <= n_held1;
        r_held2 <= n_held2;
    end

    // result queue
    lutf8_fifo #(
        .DEPTH (RES_DEPTH),
        .WIDTH ($bits(t_res))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (i_res_pop),
        .o_data  (o_res),
        .o_empty (o_res_empty)
    );

endmodule

### hw/rtl/lenient_utf8_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lenient_utf8_decoder
// Lenient UTF-8 byte stream to code point decoder with queue interfaces.
// ----------------------------------------------------------------------------
// Bytes are pushed while full is low and code points are popped while empty
// is low. The lead byte alone sets the sequence length (below 0x80 one byte,
// below 0xE0 two, below 0xF0 three, else four); there are no overlong or
// surrogate checks. A zero byte in lead position gives an end result
// (code point zero, end_of_string set) and clears the state; last marks the
// final result caused by a byte. The sequence state machine in the back end
// takes one byte per cycle while the result queue is not full, and writes at
// most one result per cycle. A byte that is not a continuation while a
// sequence is open is not popped at once: the back end first drops the lead
// (and, with three bytes held, emits the code point of the two held
// continuations), then handles the byte from idle. Each byte is registered in
// the command queue and its result in the result queue.
// ----------------------------------------------------------------------------
module lenient_utf8_decoder #(
    parameter int CMD_DEPTH = lutf8_pkg::CMD_DEPTH_DEF,
    parameter int RES_DEPTH = lutf8_pkg::RES_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic [7:0]  i_in_byte,
    output logic        full,
    output logic [20:0] o_code_point,
    output logic        o_end_of_string,
    output logic        o_last,
    output logic        empty,
    input  logic        pop
);
    import lutf8_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_empty;
    logic w_cmd_pop;
    t_res w_res;

    // front end: classify and queue bytes
    lutf8_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in_byte   (i_in_byte),
        .o_full      (full),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd),
        .o_cmd_empty (w_cmd_empty)
    );

    // back end: sequence decode and result queue
    lutf8_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_res       (w_res),
        .o_res_empty (empty),
        .i_res_pop   (pop)
    );

    assign o_code_point    = w_res.code_point;
    assign o_end_of_string = w_res.end_of_string;
    assign o_last          = w_res.last;

endmodule
